@@ rtl/sdfs_pkg.sv @@
// ----------------------------------------------------------------------------
// sdfs_pkg
// Shared types, frame layout constants and the CRC-CCITT byte update for the
// synchrophasor data frame serializer.
// ----------------------------------------------------------------------------
package sdfs_pkg;

    localparam int unsigned WordCount = 10;
    localparam int unsigned FrameLen  = 50;

    typedef logic [31:0] t_word;
    typedef t_word       t_words [WordCount];
    typedef logic [5:0]  t_pos;
    typedef logic [3:0]  t_word_idx;
    typedef logic        t_cfg_idx;

    // Byte positions inside the frame
    localparam t_pos PosSync      = 6'd0;
    localparam t_pos PosType      = 6'd1;
    localparam t_pos PosSizeHi    = 6'd2;
    localparam t_pos PosSizeLo    = 6'd3;
    localparam t_pos PosIdHi      = 6'd4;
    localparam t_pos PosIdLo      = 6'd5;
    localparam t_pos PosTimeFirst = 6'd6;
    localparam t_pos PosStatHi    = 6'd14;
    localparam t_pos PosStatLo    = 6'd15;
    localparam t_pos PosDataFirst = 6'd16;
    localparam t_pos PosCrcHi     = 6'd48;
    localparam t_pos PosCrcLo     = 6'd49;

    localparam logic [7:0]  SyncLead    = 8'hAA;
    localparam logic [7:0]  FrameSizeHi = 8'(FrameLen >> 8);
    localparam logic [7:0]  FrameSizeLo = 8'(FrameLen);
    localparam logic [7:0]  StatByte    = 8'h00;
    localparam logic [15:0] CrcInit     = 16'hFFFF;

    localparam t_cfg_idx    CfgStationId   = 1'b0;
    localparam t_cfg_idx    CfgFrameType   = 1'b1;
    localparam logic [15:0] StationIdReset = 16'h0000;
    localparam logic [7:0]  FrameTypeReset = 8'h01;

    // CRC-CCITT (0x1021), one byte, MSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        logic [7:0] q;
        t = crc[15:8] ^ b;
        q = t ^ (t >> 4);
        crc_feed = {crc[7:0], 8'h00} ^ {8'h00, q} ^ {3'b000, q, 5'b00000}
                   ^ {q[3:0], 12'h000};
    endfunction

endpackage

@@ rtl/sdfs_in_buf.sv @@
// ----------------------------------------------------------------------------
// sdfs_in_buf
// One-deep holding register for the next frame's words, so a new transaction
// is taken while the current frame is still being sent.
// ----------------------------------------------------------------------------
module sdfs_in_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sdfs_pkg::t_words i_words,
    input  logic            i_take,
    output logic            o_pend_valid,
    output sdfs_pkg::t_words o_words
);

    logic            r_pend_valid;
    sdfs_pkg::t_words r_words;
    logic            n_pend_valid;
    logic            w_accept;

    assign o_ready      = !r_pend_valid || i_take;
    assign w_accept     = i_valid && o_ready;
    assign o_pend_valid = r_pend_valid;
    assign o_words      = r_words;

    always_comb begin
        n_pend_valid = r_pend_valid;
        if (i_take) begin
            n_pend_valid = 1'b0;
        end
        if (w_accept) begin
            n_pend_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_words <= i_words;
        end
    end

endmodule

@@ rtl/sdfs_byte_gen.sv @@
// ----------------------------------------------------------------------------
// sdfs_byte_gen
// Selects the frame byte for a position and computes the CRC after it.
// ----------------------------------------------------------------------------
module sdfs_byte_gen (
    input  sdfs_pkg::t_pos   i_pos,
    input  sdfs_pkg::t_words i_words,
    input  logic [15:0]      i_crc,
    input  logic [15:0]      i_station_id,
    input  logic [7:0]       i_frame_type,
    output logic [7:0]       o_byte,
    output logic [15:0]      o_crc_next
);

    sdfs_pkg::t_pos      w_off;
    sdfs_pkg::t_word_idx w_idx;
    sdfs_pkg::t_word     w_word;
    logic [7:0]          w_lane_byte;

    // Word index and byte lane for the timestamp and data regions
    always_comb begin
        if (i_pos < sdfs_pkg::PosStatHi) begin
            w_off = i_pos - sdfs_pkg::PosTimeFirst;
            w_idx = w_off[5:2];
        end else begin
            w_off = i_pos - sdfs_pkg::PosDataFirst;
            w_idx = w_off[5:2] + 4'd2;
        end
    end

    always_comb begin
        if (w_idx < 4'(sdfs_pkg::WordCount)) begin
            w_word = i_words[w_idx];
        end else begin
            w_word = '0;
        end
    end

    always_comb begin
        unique case (w_off[1:0])
            2'd0:    w_lane_byte = w_word[31:24];
            2'd1:    w_lane_byte = w_word[23:16];
            2'd2:    w_lane_byte = w_word[15:8];
            default: w_lane_byte = w_word[7:0];
        endcase
    end

    always_comb begin
        priority if (i_pos == sdfs_pkg::PosSync) begin
            o_byte = sdfs_pkg::SyncLead;
        end else if (i_pos == sdfs_pkg::PosType) begin
            o_byte = i_frame_type;
        end else if (i_pos == sdfs_pkg::PosSizeHi) begin
            o_byte = sdfs_pkg::FrameSizeHi;
        end else if (i_pos == sdfs_pkg::PosSizeLo) begin
            o_byte = sdfs_pkg::FrameSizeLo;
        end else if (i_pos == sdfs_pkg::PosIdHi) begin
            o_byte = i_station_id[15:8];
        end else if (i_pos == sdfs_pkg::PosIdLo) begin
            o_byte = i_station_id[7:0];
        end else if (i_pos == sdfs_pkg::PosStatHi || i_pos == sdfs_pkg::PosStatLo) begin
            o_byte = sdfs_pkg::StatByte;
        end else if (i_pos == sdfs_pkg::PosCrcHi) begin
            o_byte = i_crc[15:8];
        end else if (i_pos > sdfs_pkg::PosCrcHi) begin
            o_byte = i_crc[7:0];
        end else begin
            o_byte = w_lane_byte;
        end
    end

    // CRC covers everything before the CRC field
    assign o_crc_next = (i_pos < sdfs_pkg::PosCrcHi) ? sdfs_pkg::crc_feed(i_crc, o_byte)
                                                     : i_crc;

endmodule

@@ rtl/sdfs_frame_seq.sv @@
// ----------------------------------------------------------------------------
// sdfs_frame_seq
// Byte sequencer: holds the active frame's words, position and running CRC,
// and drives the registered output byte.
// ----------------------------------------------------------------------------
module sdfs_frame_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pend_valid,
    input  sdfs_pkg::t_words i_pend_words,
    output logic             o_take,
    input  logic [15:0]      i_station_id,
    input  logic [7:0]       i_frame_type,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_frame_byte,
    output logic             o_frame_end
);

    logic             r_busy;
    sdfs_pkg::t_pos   r_pos;
    logic [15:0]      r_crc;
    sdfs_pkg::t_words r_words;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_end;

    logic             n_busy;
    sdfs_pkg::t_pos   n_pos;
    logic [15:0]      n_crc;
    logic             n_out_valid;

    logic             w_step;
    logic             w_last;
    logic [7:0]       w_byte;
    logic [15:0]      w_crc_next;

    sdfs_byte_gen u_byte_gen (
        .i_pos        (r_pos),
        .i_words      (r_words),
        .i_crc        (r_crc),
        .i_station_id (i_station_id),
        .i_frame_type (i_frame_type),
        .o_byte       (w_byte),
        .o_crc_next   (w_crc_next)
    );

    assign w_step = r_busy && (!r_out_valid || i_ready);
    assign w_last = (r_pos == sdfs_pkg::PosCrcLo);
    assign o_take = i_pend_valid && (!r_busy || (w_step && w_last));

    always_comb begin
        n_busy      = r_busy;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_out_valid = r_out_valid && !i_ready;
        if (w_step) begin
            n_out_valid = 1'b1;
            if (w_last) begin
                n_busy = 1'b0;
                n_pos  = sdfs_pkg::PosSync;
                n_crc  = sdfs_pkg::CrcInit;
            end else begin
                n_pos = r_pos + 6'd1;
                n_crc = w_crc_next;
            end
        end
        if (o_take) begin
            n_busy = 1'b1;
            n_pos  = sdfs_pkg::PosSync;
            n_crc  = sdfs_pkg::CrcInit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= sdfs_pkg::PosSync;
            r_crc       <= sdfs_pkg::CrcInit;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_words <= i_pend_words;
        end
        if (w_step) begin
            r_out_byte <= w_byte;
            r_out_end  <= w_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_end  = r_out_end;

endmodule

@@ rtl/synchrophasor_data_frame_serializer.sv @@
// ----------------------------------------------------------------------------
// synchrophasor_data_frame_serializer
// Turns one measurement transaction into a 50-byte synchrophasor data frame
// with CRC-CCITT, sent one byte per output transaction.
// ----------------------------------------------------------------------------
// Path: a transaction passes the input buffer's pending register, then the
//   sequencer's frame registers and the output byte register.
// Throughput: one byte per cycle while a frame is sent and the sink is ready.
// A second transaction is held in a one-deep buffer during the current frame.
// Reset: synchronous active low; clears all handshake state, station ID to 0
//   and frame type byte to 1.
module synchrophasor_data_frame_serializer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input transaction
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_second_of_century,
    input  logic [31:0] i_fraction_and_quality,
    input  logic [31:0] i_magnitude_r,
    input  logic [31:0] i_angle_r,
    input  logic [31:0] i_magnitude_s,
    input  logic [31:0] i_angle_s,
    input  logic [31:0] i_magnitude_t,
    input  logic [31:0] i_angle_t,
    input  logic [31:0] i_frequency_word,
    input  logic [31:0] i_rocof_word,
    // output byte transaction
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end
);

    logic [15:0]      r_station_id;
    logic [7:0]       r_frame_type;

    sdfs_pkg::t_words w_in_words;
    sdfs_pkg::t_words w_pend_words;
    logic             w_pend_valid;
    logic             w_take;

    // Configuration registers; the user must write them only while the block is
    // idle (the block itself does not enforce this), so the sequencer reads them directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_id <= sdfs_pkg::StationIdReset;
            r_frame_type <= sdfs_pkg::FrameTypeReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sdfs_pkg::CfgStationId: r_station_id <= i_cfg_data;
                sdfs_pkg::CfgFrameType: r_frame_type <= i_cfg_data[7:0];
            endcase
        end
    end

    // Pack the words in transmit order: SOC and FRACSEC first, then data
    assign w_in_words[0] = i_second_of_century;
    assign w_in_words[1] = i_fraction_and_quality;
    assign w_in_words[2] = i_magnitude_r;
    assign w_in_words[3] = i_angle_r;
    assign w_in_words[4] = i_magnitude_s;
    assign w_in_words[5] = i_angle_s;
    assign w_in_words[6] = i_magnitude_t;
    assign w_in_words[7] = i_angle_t;
    assign w_in_words[8] = i_frequency_word;
    assign w_in_words[9] = i_rocof_word;

    // Hold the next transaction while a frame is going out
    sdfs_in_buf u_in_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_words      (w_in_words),
        .i_take       (w_take),
        .o_pend_valid (w_pend_valid),
        .o_words      (w_pend_words)
    );

    // Advance through the frame one byte per accepted output slot; the next
    // frame is loaded on the cycle its predecessor's last byte is issued.
    sdfs_frame_seq u_frame_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pend_valid (w_pend_valid),
        .i_pend_words (w_pend_words),
        .o_take       (w_take),
        .i_station_id (r_station_id),
        .i_frame_type (r_frame_type),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end)
    );

endmodule

@@ rtl/sdfs_checker.sv @@
// ----------------------------------------------------------------------------
// sdfs_checker
// Port-level checks on the serializer: output hold, frame framing, the fixed
// header bytes and output valid low after reset.
// ----------------------------------------------------------------------------
module sdfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_frame_byte,
    input logic       o_frame_end
);

    logic [5:0] r_cnt;

    // Count output bytes within the current frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (o_valid && i_ready) begin
            r_cnt <= o_frame_end ? 6'd0 : r_cnt + 6'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_byte) && $stable(o_frame_end))
        else $error("output transaction changed while stalled");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_end == (r_cnt == 6'd49)))
        else $error("frame end not on byte 49");

    a_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_cnt == 6'd0 |-> o_frame_byte == 8'hAA)
        else $error("frame does not start with sync byte");

    a_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_cnt == 6'd2 || r_cnt == 6'd3)
        |-> o_frame_byte == ((r_cnt == 6'd2) ? 8'h00 : 8'd50))
        else $error("frame size field wrong");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind synchrophasor_data_frame_serializer sdfs_checker u_sdfs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_frame_byte (o_frame_byte),
    .o_frame_end  (o_frame_end)
);
